>>> rtl/ordq_pkg.sv
// Package for the output-restricted deque: shared types, operation and status
// codes, and the default sizes for the top level's parameters.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ordq_pkg;

   // Default sizes for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the ports.
   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 6;

   // Capacity register value after reset, before clamping to the store depth.
   localparam int CAP_RESET = 32;

   // Operation carried in the request tuser field.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT_HEAD = 2'd0,
      FUNC_INSERT_TAIL = 2'd1,
      FUNC_DELETE_HEAD = 2'd2,
      FUNC_TRAVERSE    = 2'd3
   } func_type;

   // Status carried in the response tuser field.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_NORM
   } state_type;

   // Strobes from the controller to the store memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/ordq_mem.sv
// Store memory of the output-restricted deque: one port, synchronous write,
// registered read.
// Depends on ordq_pkg for the strobe struct.
`default_nettype none

module ordq_mem #(
   parameter int DEPTH      = ordq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ordq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire ordq_pkg::mem_ctrl_type    mem_ctrl,
   input  wire logic [$clog2(DEPTH)-1:0]  addr,
   input  wire logic [DATA_WIDTH-1:0]     wr_data,
   output logic      [DATA_WIDTH-1:0]     rd_data
);

   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port. Contents are undefined until written, so there is no reset.
   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         store_mem[addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next read strobe.
   always_ff @(posedge clock) begin
      if (mem_ctrl.rd_en) begin
         rd_data_ff <= store_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/ordq_ctrl.sv
// Controller of the output-restricted deque: head pointer, entry count,
// capacity register, traverse sequencing and the response register.
// Depends on ordq_pkg; drives the store memory in ordq_mem.
`default_nettype none

module ordq_ctrl #(
   parameter int DEPTH      = ordq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ordq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request side.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire ordq_pkg::func_type                  req_func,
   input  wire logic signed [ordq_pkg::VALUE_W-1:0] req_value,
   // Response side.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic signed [ordq_pkg::VALUE_W-1:0]      rsp_data,
   output ordq_pkg::status_type                     rsp_status,
   output logic                                     rsp_last,
   // Capacity register write.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ordq_pkg::CSR_W-1:0]          csr_data,
   // Store memory.
   output ordq_pkg::mem_ctrl_type                   mem_ctrl,
   output logic [$clog2(DEPTH)-1:0]                 mem_addr,
   output logic [DATA_WIDTH-1:0]                    mem_wr_data,
   input  wire logic [DATA_WIDTH-1:0]               mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int CAP_RESET_EFF =
      (ordq_pkg::CAP_RESET > DEPTH) ? DEPTH : ordq_pkg::CAP_RESET;

   ordq_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        head_raw_ff, head_raw_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        cap_ff, cap_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ordq_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   ordq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 req_fire;
   logic                 csr_fire;
   logic                 full;
   logic                 empty;
   logic [AW-1:0]        head_dec;
   logic [AW-1:0]        head_inc;
   logic [AW-1:0]        ptr_inc;
   logic [CW:0]          tail_sum;
   logic [AW-1:0]        tail_idx;
   logic [CW-1:0]        head_ext;
   logic [CW-1:0]        head_nxt;
   logic [CW-1:0]        ptr_nxt;
   logic [CW-1:0]        csr_cap;

   // Handshakes. A capacity write wins over a request in the same cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = (state_ff == ordq_pkg::ST_IDLE);
   assign req_tready = (state_ff == ordq_pkg::ST_IDLE) && out_free && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   // Clamp the written capacity into the range one to DEPTH.
   always_comb begin
      if (csr_data == '0) begin
         csr_cap = CW'(1);
      end else if ({1'b0, csr_data} > (ordq_pkg::CSR_W + 1)'(DEPTH)) begin
         csr_cap = CW'(DEPTH);
      end else begin
         csr_cap = CW'(csr_data);
      end
   end

   // Index arithmetic; the head is below the capacity whenever a request is taken.
   assign full     = (count_ff >= cap_ff);
   assign empty    = (count_ff == '0);
   assign head_ext = CW'(head_ff);
   assign head_dec = (head_ff == '0) ? AW'(cap_ff - CW'(1)) : head_ff - AW'(1);
   assign head_nxt = head_ext + CW'(1);
   assign head_inc = (head_nxt == cap_ff) ? '0 : AW'(head_nxt);
   assign ptr_nxt  = CW'(ptr_ff) + CW'(1);
   assign ptr_inc  = (ptr_nxt == cap_ff) ? '0 : AW'(ptr_nxt);
   // An insert only happens below capacity, so the sum stays under twice it.
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_idx = (tail_sum >= (CW + 1)'(cap_ff)) ?
                     AW'(tail_sum - (CW + 1)'(cap_ff)) : AW'(tail_sum);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ordq_pkg::ST_IDLE: begin
            if (csr_fire) begin
               state_in = ordq_pkg::ST_NORM;
            end else if (req_fire && !empty &&
                         (req_func == ordq_pkg::FUNC_DELETE_HEAD ||
                          req_func == ordq_pkg::FUNC_TRAVERSE)) begin
               state_in = ordq_pkg::ST_READ;
            end
         end
         ordq_pkg::ST_READ: begin
            if (out_free && remain_ff == '0) begin
               state_in = ordq_pkg::ST_IDLE;
            end
         end
         ordq_pkg::ST_NORM: begin
            if (head_ext < cap_ff) begin
               state_in = ordq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ordq_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory strobes. Reads and writes come from different
   // transactions in different cycles, so one entry is never read and
   // written at the same edge. The raw head is the head as an insert or a
   // delete last set it; a capacity write reduces it afresh.
   always_comb begin
      head_in       = head_ff;
      head_raw_in   = head_raw_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      ptr_in        = ptr_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctrl      = '0;
      mem_addr      = head_ff;
      mem_wr_data   = DATA_WIDTH'(req_value);

      case (state_ff)
         ordq_pkg::ST_IDLE: begin
            if (csr_fire) begin
               cap_in  = csr_cap;
               head_in = head_raw_ff;
            end else if (req_fire) begin
               case (req_func)
                  ordq_pkg::FUNC_INSERT_HEAD,
                  ordq_pkg::FUNC_INSERT_TAIL: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = ordq_pkg::STATUS_OVERFLOW;
                     end else begin
                        rsp_status_in = ordq_pkg::STATUS_OK;
                        mem_ctrl.wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (req_func == ordq_pkg::FUNC_INSERT_HEAD) begin
                           head_in     = head_dec;
                           head_raw_in = head_dec;
                           mem_addr    = head_dec;
                        end else begin
                           head_raw_in = head_ff;
                           mem_addr    = tail_idx;
                        end
                     end
                  end
                  ordq_pkg::FUNC_DELETE_HEAD: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = ordq_pkg::STATUS_UNDERFLOW;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_ctrl.rd_en = 1'b1;
                        remain_in   = '0;
                        count_in    = count_ff - CW'(1);
                        head_in     = (count_ff == CW'(1)) ? '0 : head_inc;
                        head_raw_in = (count_ff == CW'(1)) ? '0 : head_inc;
                     end
                  end
                  ordq_pkg::FUNC_TRAVERSE: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = ordq_pkg::STATUS_UNDERFLOW;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_ctrl.rd_en = 1'b1;
                        ptr_in    = head_inc;
                        remain_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  end
               endcase
            end
         end
         ordq_pkg::ST_READ: begin
            // Hand the read entry to the response register, then fetch the
            // next one of a traverse.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ordq_pkg::VALUE_W'(mem_rd_data);
               rsp_status_in = ordq_pkg::STATUS_OK;
               rsp_last_in   = (remain_ff == '0);
               if (remain_ff != '0) begin
                  mem_ctrl.rd_en = 1'b1;
                  mem_addr  = ptr_ff;
                  ptr_in    = ptr_inc;
                  remain_in = remain_ff - CW'(1);
               end
            end
         end
         ordq_pkg::ST_NORM: begin
            // Reduce the head modulo the capacity that has just been written.
            if (head_ext >= cap_ff) begin
               head_in = AW'(head_ext - cap_ff);
            end
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ordq_pkg::ST_IDLE;
         head_ff      <= '0;
         head_raw_ff  <= '0;
         count_ff     <= '0;
         cap_ff       <= CW'(CAP_RESET_EFF);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         head_raw_ff  <= head_raw_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and sequencing registers.
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      remain_ff     <= remain_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/output_restricted_deque.sv
// Output-restricted circular deque. Each request transaction carries an
// operation in req_tuser (insert at head, insert at tail, delete head,
// traverse) and a value in req_tdata. An insert answers with one response;
// a delete reads the head entry from the store memory and then answers with
// it; a traverse of N stored entries streams N responses, the last with
// tlast. Inserting into a full deque answers overflow, deleting or
// traversing an empty one answers underflow, each with zero data. Every
// response waits in an output register; a new request is accepted only when
// that register is empty or its response leaves in the same cycle, so a
// stalled response holds off input. A capacity write on the csr channel
// (zero acts as one, values above DEPTH as DEPTH) is taken while idle and is
// followed by a head reduction that subtracts the new capacity from the head,
// as the last insert or delete left it, until it lies below the capacity.
// Depends on ordq_pkg, ordq_mem and ordq_ctrl.
`default_nettype none

module output_restricted_deque #(
   parameter int DEPTH      = ordq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ordq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request stream.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic signed [ordq_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] value
   input  wire logic [ordq_pkg::FUNC_W-1:0]           req_tuser,  // [1:0] func
   // Response stream.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic signed [ordq_pkg::VALUE_W-1:0]        rsp_tdata,  // [31:0] data
   output logic [ordq_pkg::STATUS_W-1:0]              rsp_tuser,  // [1:0] status
   output logic                                       rsp_tlast,
   // Capacity register write.
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ordq_pkg::CSR_W-1:0]            csr_data
);

   ordq_pkg::mem_ctrl_type     mem_ctrl;
   logic [$clog2(DEPTH)-1:0]   mem_addr;
   logic [DATA_WIDTH-1:0]      mem_wr_data;
   logic [DATA_WIDTH-1:0]      mem_rd_data;
   ordq_pkg::status_type       rsp_status;

   // Sequencing, pointers and response register.
   ordq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (ordq_pkg::func_type'(req_tuser)),
      .req_value   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_data    (rsp_tdata),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mem_ctrl    (mem_ctrl),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // Entry store.
   ordq_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .addr     (mem_addr),
      .wr_data  (mem_wr_data),
      .rd_data  (mem_rd_data)
   );

   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

>>> rtl/ordq_checker.sv
// Port-level checker for the output-restricted deque, bound to the top level.
// Depends on ordq_pkg for the status codes.
`default_nettype none

module ordq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Error responses carry zero data and end their operation.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ordq_pkg::STATUS_OK |-> rsp_tdata == '0 && rsp_tlast)
      else $error("error response malformed");

   // While a traverse still has entries to deliver, no request is taken.
   a_trav_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted during traverse");

   // A capacity write is followed by the head reduction state, which holds off requests.
   a_csr_norm: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("request accepted right after capacity write");

endmodule

bind output_restricted_deque ordq_checker u_ordq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire
